/* hdl/rcsfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rcsfr_pkg;

  // frame store geometry
  localparam int STORE_BYTES = 32;
  localparam int SB_AW       = $clog2(STORE_BYTES);
  localparam int IDX_W       = 6;

  // line marks and frame constants
  localparam logic [7:0] MARK_START   = 8'h7E;
  localparam logic [7:0] MARK_STUFF   = 8'h7D;
  localparam logic [7:0] STUFF_XOR    = 8'h20;
  localparam logic [7:0] LEN_CONTROL  = 8'h19;
  localparam logic [7:0] LEN_REQUEST  = 8'h08;
  localparam logic [7:0] KIND_CONTROL = 8'h00;
  localparam logic [7:0] KIND_REQUEST = 8'h01;
  localparam logic [IDX_W-1:0] CONTROL_SPAN = IDX_W'(28 - 2);
  localparam logic [7:0] RSSI_LIMIT_RESET = 8'd100;

  // store offsets of the fixed fields
  localparam int OFS_LENGTH = 0;
  localparam int OFS_KIND   = 1;
  localparam int OFS_LOW    = 2;
  localparam int OFS_MIDDLE = 10;
  localparam int OFS_HIGH   = 18;
  localparam int OFS_FLAGS  = 24;
  localparam int OFS_RSSI   = 25;
  localparam int FLAG_FAILSAFE = 3;

  typedef enum logic [2:0] {
    FS_CTRL_OK       = 3'd0,
    FS_CTRL_FAILSAFE = 3'd1,
    FS_CTRL_BAD_SUM  = 3'd2,
    FS_RSSI_BAD      = 3'd3,
    FS_REQ_OK        = 3'd4,
    FS_REQ_BAD_SUM   = 3'd5,
    FS_UNKNOWN       = 3'd6
  } frame_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_JUDGE
  } ctrl_state_t;

  typedef struct packed {
    logic take;     // process the presented item
    logic sum_clr;  // restart checksum walk
    logic step;     // fold one stored byte into the sum
    logic check;    // compare sum against the checksum byte
    logic load;     // fill output register and clear the store
  } dp_cmd_t;

  typedef struct packed {
    logic done;       // presented item completes a frame
    logic walk_last;  // walk pointer sits on the checksum byte
  } dp_stat_t;

endpackage
`default_nettype wire

/* hdl/rcsfr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module rcsfr_ctrl import rcsfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire dp_stat_t    stat,
  output dp_cmd_t          cmd,
  output ctrl_state_t      state
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take = 1'b1;
          if (stat.done) begin
            cmd.sum_clr = 1'b1;
            state_nxt   = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (stat.walk_last) begin
          cmd.check = 1'b1;
          state_nxt = ST_JUDGE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_JUDGE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign state      = state_r;

endmodule
`default_nettype wire

/* hdl/rcsfr_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module rcsfr_dp import rcsfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  output dp_stat_t         stat,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        receive_error,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_data,
  output frame_status_t    frame_status,
  output logic [7:0]       frame_kind,
  output logic [7:0]       frame_length,
  output logic [7:0]       flag_bits,
  output logic [7:0]       link_rssi,
  output logic [63:0]      payload_low,
  output logic [63:0]      payload_middle,
  output logic [47:0]      payload_high
);

  logic [7:0]       store_r [STORE_BYTES];
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             phase_r, phase_nxt;
  logic             pend_r, pend_nxt;
  logic [7:0]       sum_r;
  logic [IDX_W-1:0] walk_r;
  logic             ok_r;
  logic [7:0]       limit_r;

  frame_status_t    status_r;
  logic [7:0]       kind_r, length_r, flags_r, rssi_r;
  logic [63:0]      low_r, middle_r;
  logic [47:0]      high_r;

  logic [7:0]       b;
  logic             wr_en;
  logic [7:0]       wr_data;
  logic [IDX_W-1:0] idx_inc;
  logic             done;
  logic [IDX_W-1:0] span;
  logic [7:0]       rd;
  logic [8:0]       sum_t;
  frame_status_t    judge;
  logic [63:0]      low_c, middle_c;
  logic [47:0]      high_c;

  // byte path: unstuffing, frame hunt and store write
  always_comb begin
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    wr_en     = 1'b0;
    wr_data   = '0;
    done      = 1'b0;
    idx_inc   = idx_r + IDX_W'(1);
    b         = pend_r ? (rx_byte ^ STUFF_XOR) : rx_byte;
    if (!receive_error) begin
      if (rx_byte == MARK_START) begin
        phase_nxt = 1'b0;
        idx_nxt   = '0;
      end else if (!pend_r && rx_byte == MARK_STUFF) begin
        pend_nxt = 1'b1;
      end else begin
        pend_nxt = 1'b0;
        if (!phase_r) begin
          if (b == LEN_CONTROL || b == LEN_REQUEST) begin
            wr_en     = 1'b1;
            wr_data   = b;
            idx_nxt   = idx_inc;
            phase_nxt = 1'b1;
          end else if (b != MARK_START) begin
            idx_nxt = '0;
          end
        end else begin
          wr_en   = 1'b1;
          wr_data = b;
          idx_nxt = idx_inc;
          if (9'(idx_inc) >= 9'(store_r[OFS_LENGTH]) + 9'd2) begin
            done      = 1'b1;
            idx_nxt   = '0;
            phase_nxt = 1'b0;
          end
        end
      end
    end
  end

  // checksum walk
  always_comb begin
    if (store_r[OFS_KIND] == KIND_REQUEST) begin
      span = store_r[OFS_LENGTH][IDX_W-1:0] + IDX_W'(1);
    end else begin
      span = CONTROL_SPAN;
    end
    if (7'(walk_r) < 7'(STORE_BYTES)) begin
      rd = store_r[walk_r[SB_AW-1:0]];
    end else begin
      rd = '0;
    end
    sum_t = 9'(sum_r) + 9'(rd);
  end

  assign stat.done      = done;
  assign stat.walk_last = (walk_r == span);

  // frame verdict and packing
  always_comb begin
    if (store_r[OFS_KIND] == KIND_CONTROL) begin
      if (!ok_r) begin
        judge = FS_CTRL_BAD_SUM;
      end else if (store_r[OFS_RSSI] == 8'd0 && store_r[OFS_FLAGS][FLAG_FAILSAFE]) begin
        judge = FS_CTRL_FAILSAFE;
      end else if (store_r[OFS_RSSI] > limit_r) begin
        judge = FS_RSSI_BAD;
      end else if (store_r[OFS_FLAGS][FLAG_FAILSAFE]) begin
        judge = FS_CTRL_FAILSAFE;
      end else begin
        judge = FS_CTRL_OK;
      end
    end else if (store_r[OFS_KIND] == KIND_REQUEST) begin
      judge = ok_r ? FS_REQ_OK : FS_REQ_BAD_SUM;
    end else begin
      judge = FS_UNKNOWN;
    end
    for (int i = 0; i < 8; i++) begin
      low_c[8*i +: 8]    = store_r[OFS_LOW + i];
      middle_c[8*i +: 8] = store_r[OFS_MIDDLE + i];
    end
    for (int i = 0; i < 6; i++) begin
      high_c[8*i +: 8] = store_r[OFS_HIGH + i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      phase_r <= 1'b0;
      pend_r  <= 1'b0;
      limit_r <= RSSI_LIMIT_RESET;
      for (int i = 0; i < STORE_BYTES; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
      if (cmd.take) begin
        idx_r   <= idx_nxt;
        phase_r <= phase_nxt;
        pend_r  <= pend_nxt;
        if (wr_en && 7'(idx_r) < 7'(STORE_BYTES)) begin
          store_r[idx_r[SB_AW-1:0]] <= wr_data;
        end
      end
      if (cmd.load) begin
        for (int i = 0; i < STORE_BYTES; i++) begin
          store_r[i] <= '0;
        end
      end
    end
  end

  // walk and output registers
  always_ff @(posedge clk) begin
    if (cmd.sum_clr) begin
      sum_r  <= '0;
      walk_r <= '0;
    end else if (cmd.step) begin
      sum_r  <= sum_t[7:0] + 8'(sum_t[8]);
      walk_r <= walk_r + IDX_W'(1);
    end
    if (cmd.check) begin
      ok_r <= (~sum_r == rd);
    end
    if (cmd.load) begin
      status_r <= judge;
      kind_r   <= store_r[OFS_KIND];
      length_r <= store_r[OFS_LENGTH];
      flags_r  <= store_r[OFS_FLAGS];
      rssi_r   <= store_r[OFS_RSSI];
      low_r    <= low_c;
      middle_r <= middle_c;
      high_r   <= high_c;
    end
  end

  assign frame_status   = status_r;
  assign frame_kind     = kind_r;
  assign frame_length   = length_r;
  assign flag_bits      = flags_r;
  assign link_rssi      = rssi_r;
  assign payload_low    = low_r;
  assign payload_middle = middle_r;
  assign payload_high   = high_r;

endmodule
`default_nettype wire

/* hdl/rc_serial_frame_receiver.sv */
// byte-stuffed serial frame receiver with folded-sum checksum
//
// in channel: one received line byte per item; tuser flags a failed transfer
//   and such an item is taken and dropped. 0x7e restarts the frame hunt,
//   0x7d escapes the next byte (xor 0x20). a length byte 0x19 or 0x08 opens
//   a frame, which ends once length+2 bytes are stored.
// out channel: one item per completed frame: status, kind, length, flags,
//   rssi and the 22 payload bytes, held in an output register.
// cfg channel: writes rssi_limit (reset 100); always ready.
// throughput: one byte per cycle while a frame fills. the byte that ends a
//   frame starts a checksum walk over the 32-byte store, one byte per cycle
//   through a single read mux, up to the checksum byte at the span offset
//   (an unknown kind walks the control span), then a verdict state before
//   out_tvalid rises; in_tready is low during the walk and the verdict.
// stall: a result waits in the output register and bytes keep flowing; only
//   a second completed frame stalls in the verdict state until the first
//   result is taken.
// reset: rst_n synchronous active low; clears the store, hunt state,
//   output valid and restores rssi_limit.
`timescale 1ns / 1ps
`default_nettype none
module rc_serial_frame_receiver import rcsfr_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]   in_tuser,   // [0] receive_error
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [2:0] frame_status, [10:3] frame_kind, [18:11] frame_length,
  // [26:19] flag_bits, [34:27] link_rssi, [98:35] payload_low,
  // [162:99] payload_middle, [210:163] payload_high, [215:211] zero
  output logic [215:0]      out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_data    // rssi_limit
);

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  ctrl_state_t   state;
  frame_status_t frame_status;
  logic [7:0]    frame_kind, frame_length, flag_bits, link_rssi;
  logic [63:0]   payload_low, payload_middle;
  logic [47:0]   payload_high;

  // the user must issue register writes only while idle; not enforced here, so always accept
  assign cfg_ready = 1'b1;

  rcsfr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd),
    .state      (state)
  );

  rcsfr_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .rx_byte        (in_tdata),
    .receive_error  (in_tuser[0]),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_data       (cfg_data),
    .frame_status   (frame_status),
    .frame_kind     (frame_kind),
    .frame_length   (frame_length),
    .flag_bits      (flag_bits),
    .link_rssi      (link_rssi),
    .payload_low    (payload_low),
    .payload_middle (payload_middle),
    .payload_high   (payload_high)
  );

  // result item packing, first field lowest
  assign out_tdata = {5'd0, payload_high, payload_middle, payload_low, link_rssi,
                      flag_bits, frame_length, frame_kind, frame_status};

  // no bytes taken while the checksum walk or verdict is running
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state != ST_IDLE) |-> !in_tready)
    else $error("input taken outside idle");

  // a loaded verdict is presented on the next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_tvalid)
    else $error("loaded result not presented");

  // a new result only appears out of the verdict state
  a_rise_from_judge: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state) == ST_JUDGE)
    else $error("result appeared without a verdict");

  // a frame end always enters the checksum walk
  a_done_walks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && stat.done) |=> state == ST_SUM)
    else $error("completed frame skipped checksum walk");

endmodule
`default_nettype wire
